>>> sv/pep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pep_pkg
// shared types and constants of the previous permutation engine
// ----------------------------------------------------------------------------
package pep_pkg;

  // element width
  localparam int DATA_W = 32;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_LOAD = 11'b000_0000_0001,
    ST_SCNI = 11'b000_0000_0010,
    ST_SCNJ = 11'b000_0000_0100,
    ST_SWPI = 11'b000_0000_1000,
    ST_SWPJ = 11'b000_0001_0000,
    ST_RVRL = 11'b000_0010_0000,
    ST_RVRH = 11'b000_0100_0000,
    ST_RVWL = 11'b000_1000_0000,
    ST_RVWH = 11'b001_0000_0000,
    ST_EMRD = 11'b010_0000_0000,
    ST_EMLD = 11'b100_0000_0000
  } pep_state_t;

endpackage : pep_pkg
`default_nettype wire

>>> sv/pep_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pep_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pep_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [pep_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [pep_pkg::DATA_W-1:0] rdata
);
  import pep_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // registered read: data follows the read enable in the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule : pep_mem
`default_nettype wire

>>> sv/previous_permutation_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// previous_permutation_engine_core
// turns a loaded sequence into its previous lexicographic permutation
// ----------------------------------------------------------------------------
// Elements stream in one beat per cycle and are written into a MAX_LEN entry
// store; elements beyond MAX_LEN are dropped and the result flags overflow.
// The beat marked last closes the sequence: the input then stalls while the
// engine works on the store through its single read port and single write
// port (read data registered). After the last beat the engine runs a
// right-to-left scan for the pivot i, a right-to-left scan for the swap
// partner j, the swap, the reversal of the suffix one element pair at a
// time, and the emission of the beats. A non-decreasing sequence skips the
// swap and reversal and is sent out as is with out_unchanged set. The
// output register decouples the two sides: loading of the next sequence
// starts as soon as the final beat sits in the output register, even if
// the receiver still stalls it.
// ----------------------------------------------------------------------------
module previous_permutation_engine_core #(
  parameter int MAX_LEN = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [pep_pkg::DATA_W-1:0] in_value,
  input  wire logic                             in_last,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed      [pep_pkg::DATA_W-1:0] out_value,
  output logic                                  out_last,
  output logic                                  out_unchanged,
  output logic                                  out_overflow
);
  import pep_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  // sequencer and load bookkeeping
  pep_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_seen_r, ovf_seen_nxt;
  logic [IDX_W-1:0] n_m1_r, n_m1_nxt;       // index of the last stored element

  // scan pipeline: address in flight and its returning data
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;
  logic             rv_r, rv_nxt;
  logic             hp_r, hp_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;

  // pivot, partner and reversal pointers
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic signed [DATA_W-1:0] ai_r, ai_nxt;
  logic signed [DATA_W-1:0] aj_r, aj_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic signed [DATA_W-1:0] tmp_r, tmp_nxt;

  // emission
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             unch_r, unch_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_unch_r, out_unch_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  // store ports
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr;
  logic [DATA_W-1:0]        mem_rdata;
  logic signed [DATA_W-1:0] rdata;

  // helpers
  logic             in_acc;
  logic             out_take;
  logic             room;
  logic [CNT_W-1:0] cnt_inc;
  logic             ovf_inc;
  logic [IDX_W-1:0] i_p1;
  logic [IDX_W-1:0] lo_p1;
  logic [IDX_W-1:0] hi_m1;

  pep_mem #(
    .DEPTH (MAX_LEN),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rdata    = $signed(mem_rdata);
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  // element count after this beat; a full store drops the beat
  assign room    = (cnt_r < CNT_MAX);
  assign cnt_inc = room ? cnt_r + 1'b1 : cnt_r;
  assign ovf_inc = ovf_seen_r | ~room;

  assign i_p1  = i_r + 1'b1;
  assign lo_p1 = lo_r + 1'b1;
  assign hi_m1 = hi_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_seen_nxt  = ovf_seen_r;
    n_m1_nxt      = n_m1_r;
    ptr_nxt       = ptr_r;
    ra_nxt        = ra_r;
    rv_nxt        = rv_r;
    hp_nxt        = hp_r;
    prev_nxt      = prev_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ai_nxt        = ai_r;
    aj_nxt        = aj_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tmp_nxt       = tmp_r;
    k_nxt         = k_r;
    unch_nxt      = unch_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_take;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_unch_nxt  = out_unch_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IDX_W-1:0];
            mem_wdata = in_value;
          end
          if (in_last) begin
            // close the sequence, start the pivot scan from the right end
            n_m1_nxt     = IDX_W'(cnt_inc - 1'b1);
            ptr_nxt      = IDX_W'(cnt_inc - 1'b1);
            ovf_nxt      = ovf_inc;
            cnt_nxt      = '0;
            ovf_seen_nxt = 1'b0;
            rv_nxt       = 1'b0;
            hp_nxt       = 1'b0;
            k_nxt        = '0;
            if (cnt_inc == CNT_W'(1)) begin
              unch_nxt  = 1'b1;
              state_nxt = ST_EMRD;
            end else begin
              unch_nxt  = 1'b0;
              state_nxt = ST_SCNI;
            end
          end else begin
            cnt_nxt      = cnt_inc;
            ovf_seen_nxt = ovf_inc;
          end
        end
      end

      ST_SCNI: begin
        // read one element a cycle, right to left
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
        ra_nxt    = ptr_r;
        rv_nxt    = 1'b1;
        if (ptr_r != '0) begin
          ptr_nxt = ptr_r - 1'b1;
        end
        if (rv_r) begin
          if (!hp_r) begin
            prev_nxt = rdata;
            hp_nxt   = 1'b1;
          end else if (prev_r < rdata) begin
            // pivot found
            i_nxt     = ra_r;
            ai_nxt    = rdata;
            ptr_nxt   = n_m1_r;
            rv_nxt    = 1'b0;
            state_nxt = ST_SCNJ;
          end else if (ra_r == '0) begin
            // already the smallest arrangement
            unch_nxt  = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_EMRD;
          end else begin
            prev_nxt = rdata;
          end
        end
      end

      ST_SCNJ: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
        ra_nxt    = ptr_r;
        rv_nxt    = 1'b1;
        if (ptr_r != '0) begin
          ptr_nxt = ptr_r - 1'b1;
        end
        // right neighbor of the pivot always qualifies
        if (rv_r && ((rdata < ai_r) || (ra_r == i_p1))) begin
          j_nxt     = ra_r;
          aj_nxt    = rdata;
          state_nxt = ST_SWPI;
        end
      end

      ST_SWPI: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = aj_r;
        lo_nxt    = i_p1;
        hi_nxt    = n_m1_r;
        state_nxt = ST_SWPJ;
      end

      ST_SWPJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = ai_r;
        k_nxt     = '0;
        state_nxt = (lo_r < hi_r) ? ST_RVRL : ST_EMRD;
      end

      ST_RVRL: begin
        mem_re    = 1'b1;
        mem_raddr = lo_r;
        state_nxt = ST_RVRH;
      end

      ST_RVRH: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
        tmp_nxt   = rdata;
        state_nxt = ST_RVWL;
      end

      ST_RVWL: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = rdata;
        state_nxt = ST_RVWH;
      end

      ST_RVWH: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        lo_nxt    = lo_p1;
        hi_nxt    = hi_m1;
        state_nxt = (lo_p1 < hi_m1) ? ST_RVRL : ST_EMRD;
      end

      ST_EMRD: begin
        // fetch only when the output register is free at the next edge
        if (!out_valid_r || !out_stall) begin
          mem_re    = 1'b1;
          mem_raddr = k_r;
          state_nxt = ST_EMLD;
        end
      end

      ST_EMLD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rdata;
        out_last_nxt  = (k_r == n_m1_r);
        out_unch_nxt  = unch_r;
        out_ovf_nxt   = ovf_r;
        if (k_r == n_m1_r) begin
          state_nxt = ST_LOAD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_EMRD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_seen_r  <= 1'b0;
      rv_r        <= 1'b0;
      hp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      rv_r        <= rv_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_m1_r      <= n_m1_nxt;
    ptr_r       <= ptr_nxt;
    ra_r        <= ra_nxt;
    prev_r      <= prev_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    ai_r        <= ai_nxt;
    aj_r        <= aj_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    tmp_r       <= tmp_nxt;
    k_r         <= k_nxt;
    unch_r      <= unch_nxt;
    ovf_r       <= ovf_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_unch_r  <= out_unch_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_unchanged = out_unch_r;
  assign out_overflow  = out_ovf_r;

`ifndef SYNTHESIS
  // a waiting beat that is not the final one means emission is in progress
  ap_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMRD))
    else $error("non-final beat held outside emission");

  // element count never passes the store depth
  ap_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("element count beyond store depth");

  // partner scan never reaches the pivot itself
  ap_scan_j: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCNJ && rv_r) |-> (ra_r > i_r))
    else $error("partner scan passed the pivot");

  // store is not written while beats are emitted
  ap_no_wr_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMRD || state_r == ST_EMLD) |-> !mem_we)
    else $error("store written during emission");
`endif

endmodule : previous_permutation_engine_core
`default_nettype wire
